@@ sv/dst_pkg.sv @@
// ----------------------------------------------------------------------------
// dst_pkg
// Shared types and constants of the drum step trigger: field widths, the
// request and result structs, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package dst_pkg;

  // Fixed point format of the playhead.
  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 48;

  // Field widths.
  localparam int NUM_W   = 6;
  localparam int DEN_W   = 6;
  localparam int DIV_W   = 6;
  localparam int RND_W   = 16;
  localparam int PROB_W  = 17;
  localparam int VEL_W   = 7;
  localparam int NOTE_W  = 7;

  // Dividend of the step length: numerator times four, shifted by FRAC_BITS.
  localparam int DVD_W   = NUM_W + 2 + FRAC_BITS;
  // Product of denominator and division.
  localparam int PROD_W  = DEN_W + DIV_W;
  // Iteration counter of the divider, able to hold POS_W.
  localparam int CNT_W   = $clog2(POS_W + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = PROB_W;

  // Register reset values.
  localparam logic [PROB_W-1:0] PROB_RESET = PROB_W'(65536);
  localparam logic [DIV_W-1:0]  DIV_RESET  = DIV_W'(4);
  localparam logic [VEL_W-1:0]  VEL_RESET  = VEL_W'(127);
  localparam logic [NOTE_W-1:0] NOTE_RESET = NOTE_W'(36);

  // One quarter note, the value the last step position returns to.
  localparam logic [POS_W-1:0] QUARTER = POS_W'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MUTE,
    REG_PROBABILITY,
    REG_DIVISION,
    REG_VELOCITY,
    REG_OFFBEAT,
    REG_NOTE
  } reg_idx_t;

  typedef struct packed {
    logic              mute;
    logic [PROB_W-1:0] probability;
    logic [DIV_W-1:0]  division;
    logic [VEL_W-1:0]  velocity;
    logic              offbeat_mode;
    logic [NOTE_W-1:0] note_number;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [NUM_W-1:0] sig_numerator;
    logic [DEN_W-1:0] sig_denominator;
    logic [RND_W-1:0] random_value;
  } in_item_t;

  typedef struct packed {
    logic              is_note_on;
    logic [NOTE_W-1:0] event_note;
    logic [VEL_W-1:0]  event_velocity;
    logic              last_event;
  } out_item_t;

  // Command to the shared divider.
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] iters;
    logic [POS_W-1:0] dividend;
    logic [POS_W-1:0] divisor;
  } div_req_t;

  // Status and results of the shared divider.
  typedef struct packed {
    logic             busy;
    logic [POS_W-1:0] quotient;
    logic [POS_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN_GO,
    ST_LEN_RUN,
    ST_BAR_GO,
    ST_BAR_RUN,
    ST_STEP_GO,
    ST_STEP_RUN,
    ST_DECIDE,
    ST_SEND
  } st_t;

endpackage

`default_nettype wire

@@ sv/dst_div_unit.sv @@
// ----------------------------------------------------------------------------
// dst_div_unit
// Shared restoring divider, one quotient bit per cycle. The dividend is
// left-aligned in a POS_W shift register; after "iters" steps the low bits
// of that register hold the quotient and the remainder register holds the
// remainder. A zero divisor leaves the dividend as the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module dst_div_unit
  import dst_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [POS_W-1:0] rem;
  logic [POS_W-1:0] shreg;
  logic [POS_W-1:0] dsr;

  logic [POS_W:0]   rem_sh;
  logic [POS_W:0]   rem_diff;
  logic             ge;

  // Trial subtraction of one step.
  always_comb begin
    rem_sh   = {rem, shreg[POS_W-1]};
    ge       = rem_sh >= {1'b0, dsr};
    rem_diff = rem_sh - {1'b0, dsr};
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= req.iters;
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= '0;
      shreg <= req.dividend;
      dsr   <= req.divisor;
    end else if (busy) begin
      rem   <= ge ? rem_diff[POS_W-1:0] : rem_sh[POS_W-1:0];
      shreg <= {shreg[POS_W-2:0], ge};
    end
  end

  assign rsp.busy      = busy;
  assign rsp.quotient  = shreg;
  assign rsp.remainder = rem;

endmodule

`default_nettype wire

@@ sv/dst_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// dst_cfg_regs
// Configuration register file of the drum step trigger. Writes to an index
// past the last register are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module dst_cfg_regs
  import dst_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  // Register writes, decoded by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mute         <= 1'b0;
      cfg.probability  <= PROB_RESET;
      cfg.division     <= DIV_RESET;
      cfg.velocity     <= VEL_RESET;
      cfg.offbeat_mode <= 1'b0;
      cfg.note_number  <= NOTE_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_MUTE:        cfg.mute         <= wr_data[0];
        REG_PROBABILITY: cfg.probability  <= wr_data[PROB_W-1:0];
        REG_DIVISION:    cfg.division     <= wr_data[DIV_W-1:0];
        REG_VELOCITY:    cfg.velocity     <= wr_data[VEL_W-1:0];
        REG_OFFBEAT:     cfg.offbeat_mode <= wr_data[0];
        REG_NOTE:        cfg.note_number  <= wr_data[NOTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/drum_step_trigger.sv @@
// ----------------------------------------------------------------------------
// drum_step_trigger
// One drum track of a step sequencer: turns a playhead tick into note-on and
// note-off events.
// ----------------------------------------------------------------------------
// A tick is taken only while the block is idle. An unmuted tick runs three
// passes of one shared bit-serial divider: the step length (DVD_W = 24
// steps), the position modulo one bar (48 steps) and that remainder modulo
// the step length (48 steps). A muted tick skips the divider: it passes from
// ST_IDLE to ST_DECIDE and, only if a note is held, on to ST_SEND, where its
// note-off is offered. Up to two events follow, one per accepted output
// request, and the next tick is taken after the last one.
// Configuration writes are always accepted and must only be made while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module drum_step_trigger
  import dst_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  st_t      state;
  st_t      state_next;

  in_item_t in_q;
  logic [POS_W-1:0] step_len;
  logic [POS_W-1:0] step_len_next;
  logic [POS_W-1:0] prev_pos;
  logic             note_held;
  logic             offbeat_done;
  logic [1:0]       ev_on;
  logic [1:0]       ev_cnt;
  logic             idx;

  logic [PROD_W-1:0] prod;
  logic [DVD_W-1:0]  len_dvd;
  logic              len_zero;

  // Decision results.
  logic [POS_W-1:0] step_pos;
  logic             half;
  logic             wrap;
  logic             fire;
  logic             held_next;
  logic             done_next;
  logic [1:0]       on_next;
  logic [1:0]       cnt_next;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  dst_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Shared divider.
  dst_div_unit u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Operands of the step length division.
  always_comb begin
    prod     = PROD_W'(in_q.sig_denominator) * PROD_W'(cfg.division);
    len_dvd  = DVD_W'({in_q.sig_numerator, 2'b00}) << FRAC_BITS;
    len_zero = (prod == '0);
    step_len_next = len_zero ? {POS_W{1'b1}} : POS_W'(div_rsp.quotient[DVD_W-1:0]);
  end

  // Event decision, in the order half step first, then wrap.
  always_comb begin
    logic h;
    logic od;
    logic [1:0] n;
    logic [1:0] on;
    step_pos = div_rsp.remainder;
    half     = {step_pos, 1'b0} >= {1'b0, step_len};
    wrap     = step_pos < prev_pos;
    fire     = cfg.probability >= PROB_W'(in_q.random_value);
    h  = note_held;
    od = offbeat_done;
    n  = 2'd0;
    on = 2'b00;
    if (cfg.mute) begin
      if (h) begin
        n = 2'd1;
      end
      h = 1'b0;
    end else begin
      if (half) begin
        if (!h && cfg.offbeat_mode && !od) begin
          if (fire) begin
            on[n[0]] = 1'b1;
            n = n + 2'd1;
            h = 1'b1;
          end
          od = 1'b1;
        end
        if (h && !cfg.offbeat_mode) begin
          n = n + 2'd1;
          h = 1'b0;
        end
      end
      if (wrap) begin
        od = 1'b0;
        if (h && cfg.offbeat_mode) begin
          n = n + 2'd1;
          h = 1'b0;
        end
        if (!h && !cfg.offbeat_mode && fire) begin
          on[n[0]] = 1'b1;
          n = n + 2'd1;
          h = 1'b1;
        end
      end
    end
    held_next = h;
    done_next = od;
    on_next   = on;
    cnt_next  = n;
  end

  // Sequencer: next state and divider commands.
  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.iters    = CNT_W'(POS_W);
    div_req.dividend = in_q.position;
    div_req.divisor  = POS_W'({in_q.sig_numerator, {FRAC_BITS{1'b0}}});
    in_ready         = 1'b0;
    out_valid        = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = cfg.mute ? ST_DECIDE : ST_LEN_GO;
        end
      end
      ST_LEN_GO: begin
        div_req.start    = 1'b1;
        div_req.iters    = CNT_W'(DVD_W);
        div_req.dividend = POS_W'(len_dvd) << (POS_W - DVD_W);
        div_req.divisor  = POS_W'(prod);
        state_next       = ST_LEN_RUN;
      end
      ST_LEN_RUN: begin
        if (!div_rsp.busy) begin
          state_next = ST_BAR_GO;
        end
      end
      ST_BAR_GO: begin
        div_req.start = 1'b1;
        state_next    = ST_BAR_RUN;
      end
      ST_BAR_RUN: begin
        if (!div_rsp.busy) begin
          state_next = ST_STEP_GO;
        end
      end
      ST_STEP_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = div_rsp.remainder;
        div_req.divisor  = step_len;
        state_next       = ST_STEP_RUN;
      end
      ST_STEP_RUN: begin
        if (!div_rsp.busy) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = (cnt_next == 2'd0) ? ST_IDLE : ST_SEND;
      end
      ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready && out_data.last_event) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      note_held    <= 1'b0;
      offbeat_done <= 1'b0;
      prev_pos     <= QUARTER;
      ev_cnt       <= 2'd0;
      idx          <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DECIDE) begin
        note_held    <= held_next;
        offbeat_done <= done_next;
        prev_pos     <= cfg.mute ? QUARTER : step_pos;
        ev_cnt       <= cnt_next;
        idx          <= 1'b0;
      end else if (state == ST_SEND && out_ready) begin
        idx <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
    if (state == ST_BAR_GO) begin
      step_len <= step_len_next;
    end
    if (state == ST_DECIDE) begin
      ev_on <= on_next;
    end
  end

  // Result request.
  always_comb begin
    out_data.is_note_on     = ev_on[idx];
    out_data.event_note     = cfg.note_number;
    out_data.event_velocity = ev_on[idx] ? cfg.velocity : '0;
    out_data.last_event     = idx || (ev_cnt == 2'd1);
  end

  // The sequencer only offers a request when it has events to send.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ev_cnt == 2'd1 || ev_cnt == 2'd2))
    else $error("result offered with no pending event");

  // After the last event of a tick the block is ready for the next one.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.last_event) |=> in_ready)
    else $error("block not idle after last event");

  // The divider is never left running while a new tick can be taken.
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !div_rsp.busy)
    else $error("divider busy while idle");

  // A muted tick always leaves no note held and the last step position at QUARTER.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE && cfg.mute) |=> (!note_held && prev_pos == QUARTER))
    else $error("muted tick left a note held");

endmodule

`default_nettype wire
